@@ rtl/core/ffpa_pkg.sv @@
// Shared types, constants and codes for the first-fit page allocator.
// Used by ffpa_ctrl, ffpa_dp and first_fit_page_allocator; depends on nothing.
`default_nettype none

package ffpa_pkg;

  localparam int NUM_PAGES  = 1024;
  localparam int ADDR_W     = $clog2(NUM_PAGES);
  localparam int LEN_W      = ADDR_W + 1;

  localparam int MODE_W      = 1;
  localparam int COUNT_W     = 11;
  localparam int OWNER_W     = 16;
  localparam int INDEX_W     = 10;
  localparam int START_W     = 10;
  localparam int ERR_W       = 2;
  localparam int TOTAL_W     = 11;
  localparam int RESERVED_W  = 10;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;

  localparam int TOTAL_RESET    = 1024;
  localparam int RESERVED_RESET = 1;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_PAGES    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_PAGES = 1'b1;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE,
    ERR_NO_SPACE,
    ERR_ZERO_COUNT,
    ERR_NOT_BLOCK
  } err_code_t;

  // One entry of the page table. Only entries with start set carry meaning.
  typedef struct packed {
    logic               start;
    logic               used;
    logic [LEN_W-1:0]   len;
    logic [OWNER_W-1:0] owner;
  } page_entry_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD_REQ,
    DP_CLR_WRITE,
    DP_INIT_RES,
    DP_INIT_FREE,
    DP_RD_P,
    DP_STEP,
    DP_RD_IDX,
    DP_LATCH_IDX,
    DP_RD_NXT,
    DP_MERGE_NXT,
    DP_WR_SPLIT,
    DP_WR_ALLOC,
    DP_WR_PREV,
    DP_WR_IDX_ZERO,
    DP_WR_IDX_FREE
  } dp_op_t;

  typedef struct packed {
    dp_op_t    op;
    logic      res_en;
    err_code_t res_err;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic p_end;
    logic p_before_idx;
    logic count_zero;
    logic mode_free;
    logic idx_out;
    logic fit;
    logic split;
    logic idx_ok;
    logic nxt_in;
    logic nxt_free;
    logic prev_merge;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_INIT_RES,
    ST_INIT_FREE,
    ST_IDLE,
    ST_DECODE,
    ST_A_CHECK,
    ST_A_EVAL,
    ST_A_ALLOC,
    ST_F_EVAL_IDX,
    ST_F_CHECK_NXT,
    ST_F_EVAL_NXT,
    ST_F_WALK_CHECK,
    ST_F_WALK_EVAL,
    ST_F_FINISH,
    ST_F_WR_IDX
  } ctrl_state_t;

endpackage

`default_nettype wire

@@ rtl/core/first_fit_page_allocator.sv @@
// Top level of the first-fit page allocator with two-sided coalescing.
// Instantiates ffpa_ctrl and ffpa_dp; uses ffpa_pkg.
//
// Usage: a request word is taken at a rising edge where start is high and
// busy is low. mode selects allocate (page_count pages tagged with owner_id)
// or free (the block starting at page_index). Exactly one result word follows:
// done is high for one cycle with ok, start_page and error_code valid. The
// receiver cannot stall, so the result must be captured in that cycle.
// The walk over extents goes through the single page table memory, one read
// and one evaluate step per extent visited. An allocate walks up to the first
// extent that fits; a free walks the extents below the freed page. Zero counts
// and out-of-pool frees are answered from the decode state, without a walk.
// One request is in flight at a time; busy stays high until the result is
// issued.
// Configuration words (index 0 pool size, index 1 reserved size) are taken
// when cfg_valid and cfg_ready are both high, while no request is in flight.
// After reset and after every configuration word the page table is rebuilt:
// a clearing pass writes all 1024 entries, one per cycle, then the reserved
// and free blocks are laid down, with busy high throughout.
`default_nettype none

module first_fit_page_allocator (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire  [ffpa_pkg::MODE_W-1:0]      mode,
  input  wire  [ffpa_pkg::COUNT_W-1:0]     page_count,
  input  wire  [ffpa_pkg::OWNER_W-1:0]     owner_id,
  input  wire  [ffpa_pkg::INDEX_W-1:0]     page_index,
  output logic                             done,
  output logic                             ok,
  output logic [ffpa_pkg::START_W-1:0]     start_page,
  output logic [ffpa_pkg::ERR_W-1:0]       error_code,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [ffpa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [ffpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ffpa_pkg::dp_cmd_t    cmd;
  ffpa_pkg::dp_status_t status;
  logic                 cfg_wr;

  // A configuration word lands in the datapath registers and restarts the
  // rebuild in the controller in the same cycle.
  assign cfg_wr = cfg_valid && cfg_ready;

  ffpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_wr    (cfg_wr),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready)
  );

  ffpa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .page_count (page_count),
    .owner_id   (owner_id),
    .page_index (page_index),
    .cmd        (cmd),
    .status     (status),
    .done       (done),
    .ok         (ok),
    .start_page (start_page),
    .error_code (error_code)
  );

  // An accepted request keeps the block busy and cannot be answered at once.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("request accepted but block not busy or result too early");

  // A result is only issued on the way back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a request is still in progress");

  // Success and error code agree, and failures report page zero.
  a_result_consistent: assert property (@(posedge clk) disable iff (rst)
    done |-> ((ok == (error_code == ffpa_pkg::ERR_NONE)) && (ok || (start_page == '0))))
    else $error("inconsistent result word");

endmodule

`default_nettype wire

@@ rtl/core/ffpa_ctrl.sv @@
// Sequencing state machine of the page allocator.
// Issues datapath commands and reads datapath status; uses ffpa_pkg.
`default_nettype none

module ffpa_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire                 cfg_wr,
  input  ffpa_pkg::dp_status_t status,
  output ffpa_pkg::dp_cmd_t   cmd,
  output logic                busy,
  output logic                cfg_ready
);

  ffpa_pkg::ctrl_state_t state;
  ffpa_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffpa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.op      = ffpa_pkg::DP_NOP;
    cmd.res_en  = 1'b0;
    cmd.res_err = ffpa_pkg::ERR_NONE;
    unique case (state)
      ffpa_pkg::ST_CLEAR: begin
        cmd.op = ffpa_pkg::DP_CLR_WRITE;
        if (status.clr_last) begin
          state_next = ffpa_pkg::ST_INIT_RES;
        end
      end
      ffpa_pkg::ST_INIT_RES: begin
        cmd.op     = ffpa_pkg::DP_INIT_RES;
        state_next = ffpa_pkg::ST_INIT_FREE;
      end
      ffpa_pkg::ST_INIT_FREE: begin
        cmd.op     = ffpa_pkg::DP_INIT_FREE;
        state_next = ffpa_pkg::ST_IDLE;
      end
      ffpa_pkg::ST_IDLE: begin
        if (start) begin
          cmd.op     = ffpa_pkg::DP_LOAD_REQ;
          state_next = ffpa_pkg::ST_DECODE;
        end
      end
      ffpa_pkg::ST_DECODE: begin
        if (status.mode_free) begin
          if (status.idx_out) begin
            cmd.res_en  = 1'b1;
            cmd.res_err = ffpa_pkg::ERR_NOT_BLOCK;
            state_next  = ffpa_pkg::ST_IDLE;
          end else begin
            cmd.op     = ffpa_pkg::DP_RD_IDX;
            state_next = ffpa_pkg::ST_F_EVAL_IDX;
          end
        end else if (status.count_zero) begin
          cmd.res_en  = 1'b1;
          cmd.res_err = ffpa_pkg::ERR_ZERO_COUNT;
          state_next  = ffpa_pkg::ST_IDLE;
        end else begin
          state_next = ffpa_pkg::ST_A_CHECK;
        end
      end
      ffpa_pkg::ST_A_CHECK: begin
        if (status.p_end) begin
          cmd.res_en  = 1'b1;
          cmd.res_err = ffpa_pkg::ERR_NO_SPACE;
          state_next  = ffpa_pkg::ST_IDLE;
        end else begin
          cmd.op     = ffpa_pkg::DP_RD_P;
          state_next = ffpa_pkg::ST_A_EVAL;
        end
      end
      ffpa_pkg::ST_A_EVAL: begin
        if (status.fit) begin
          if (status.split) begin
            cmd.op     = ffpa_pkg::DP_WR_SPLIT;
            state_next = ffpa_pkg::ST_A_ALLOC;
          end else begin
            cmd.op     = ffpa_pkg::DP_WR_ALLOC;
            cmd.res_en = 1'b1;
            state_next = ffpa_pkg::ST_IDLE;
          end
        end else begin
          cmd.op     = ffpa_pkg::DP_STEP;
          state_next = ffpa_pkg::ST_A_CHECK;
        end
      end
      ffpa_pkg::ST_A_ALLOC: begin
        cmd.op     = ffpa_pkg::DP_WR_ALLOC;
        cmd.res_en = 1'b1;
        state_next = ffpa_pkg::ST_IDLE;
      end
      ffpa_pkg::ST_F_EVAL_IDX: begin
        if (status.idx_ok) begin
          cmd.op     = ffpa_pkg::DP_LATCH_IDX;
          state_next = ffpa_pkg::ST_F_CHECK_NXT;
        end else begin
          cmd.res_en  = 1'b1;
          cmd.res_err = ffpa_pkg::ERR_NOT_BLOCK;
          state_next  = ffpa_pkg::ST_IDLE;
        end
      end
      ffpa_pkg::ST_F_CHECK_NXT: begin
        if (status.nxt_in) begin
          cmd.op     = ffpa_pkg::DP_RD_NXT;
          state_next = ffpa_pkg::ST_F_EVAL_NXT;
        end else begin
          state_next = ffpa_pkg::ST_F_WALK_CHECK;
        end
      end
      ffpa_pkg::ST_F_EVAL_NXT: begin
        if (status.nxt_free) begin
          cmd.op = ffpa_pkg::DP_MERGE_NXT;
        end
        state_next = ffpa_pkg::ST_F_WALK_CHECK;
      end
      ffpa_pkg::ST_F_WALK_CHECK: begin
        if (status.p_before_idx) begin
          cmd.op     = ffpa_pkg::DP_RD_P;
          state_next = ffpa_pkg::ST_F_WALK_EVAL;
        end else begin
          state_next = ffpa_pkg::ST_F_FINISH;
        end
      end
      ffpa_pkg::ST_F_WALK_EVAL: begin
        cmd.op     = ffpa_pkg::DP_STEP;
        state_next = ffpa_pkg::ST_F_WALK_CHECK;
      end
      ffpa_pkg::ST_F_FINISH: begin
        if (status.prev_merge) begin
          cmd.op     = ffpa_pkg::DP_WR_PREV;
          state_next = ffpa_pkg::ST_F_WR_IDX;
        end else begin
          cmd.op     = ffpa_pkg::DP_WR_IDX_FREE;
          cmd.res_en = 1'b1;
          state_next = ffpa_pkg::ST_IDLE;
        end
      end
      ffpa_pkg::ST_F_WR_IDX: begin
        cmd.op     = ffpa_pkg::DP_WR_IDX_ZERO;
        cmd.res_en = 1'b1;
        state_next = ffpa_pkg::ST_IDLE;
      end
      default: begin
        state_next = ffpa_pkg::ST_CLEAR;
      end
    endcase
    // A register write rebuilds the layout, so the clearing pass restarts.
    if (cfg_wr) begin
      state_next = ffpa_pkg::ST_CLEAR;
    end
  end

  assign busy      = (state != ffpa_pkg::ST_IDLE);
  // A request taken in the same cycle goes first; the register write waits for it.
  assign cfg_ready = ((state == ffpa_pkg::ST_IDLE) && !start) ||
                     (state == ffpa_pkg::ST_CLEAR) ||
                     (state == ffpa_pkg::ST_INIT_RES) || (state == ffpa_pkg::ST_INIT_FREE);

endmodule

`default_nettype wire

@@ rtl/core/ffpa_dp.sv @@
// Datapath of the page allocator: page table memory, walk pointer, config
// registers and the result register. Driven by ffpa_ctrl; uses ffpa_pkg.
`default_nettype none

module ffpa_dp (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_wr,
  input  wire  [ffpa_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [ffpa_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire  [ffpa_pkg::MODE_W-1:0]           mode,
  input  wire  [ffpa_pkg::COUNT_W-1:0]          page_count,
  input  wire  [ffpa_pkg::OWNER_W-1:0]          owner_id,
  input  wire  [ffpa_pkg::INDEX_W-1:0]          page_index,
  input  ffpa_pkg::dp_cmd_t                     cmd,
  output ffpa_pkg::dp_status_t                  status,
  output logic                                  done,
  output logic                                  ok,
  output logic [ffpa_pkg::START_W-1:0]          start_page,
  output logic [ffpa_pkg::ERR_W-1:0]            error_code
);

  localparam int ADDR_W = ffpa_pkg::ADDR_W;
  localparam int LEN_W  = ffpa_pkg::LEN_W;

  ffpa_pkg::page_entry_t mem [ffpa_pkg::NUM_PAGES];
  ffpa_pkg::page_entry_t rd;

  logic [ffpa_pkg::TOTAL_W-1:0]    total_pages;
  logic [ffpa_pkg::RESERVED_W-1:0] reserved_pages;
  logic [ADDR_W-1:0]               clr_cnt;

  logic [ffpa_pkg::MODE_W-1:0]  req_mode;
  logic [ffpa_pkg::COUNT_W-1:0] req_count;
  logic [ffpa_pkg::OWNER_W-1:0] req_owner;
  logic [ffpa_pkg::INDEX_W-1:0] req_idx;

  logic [LEN_W-1:0]  p;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  nxt;
  logic [ADDR_W-1:0] prev_p;
  logic [LEN_W-1:0]  prev_len;
  logic              prev_start;
  logic              prev_used;
  logic              has_prev;

  ffpa_pkg::err_code_t err_reg;

  logic [LEN_W-1:0] tp;
  logic [LEN_W-1:0] rp;
  logic [LEN_W-1:0] res_ext;
  logic [LEN_W-1:0] count_ext;
  logic [LEN_W-1:0] idx_ext;
  logic [LEN_W-1:0] step;
  logic [LEN_W-1:0] split_pos;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  ffpa_pkg::page_entry_t wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;

  // Effective pool and reserved sizes, saturated to their legal ranges.
  always_comb begin
    res_ext = LEN_W'(reserved_pages);
    if (total_pages > ffpa_pkg::TOTAL_W'(ffpa_pkg::NUM_PAGES)) begin
      tp = LEN_W'(ffpa_pkg::NUM_PAGES);
    end else if (total_pages < ffpa_pkg::TOTAL_W'(2)) begin
      tp = LEN_W'(2);
    end else begin
      tp = LEN_W'(total_pages);
    end
    if (res_ext == '0) begin
      rp = LEN_W'(1);
    end else if (res_ext > tp - LEN_W'(1)) begin
      rp = tp - LEN_W'(1);
    end else begin
      rp = res_ext;
    end
  end

  assign count_ext = LEN_W'(req_count);
  assign idx_ext   = LEN_W'(req_idx);
  assign step      = (rd.len == '0) ? LEN_W'(1) : rd.len;
  assign split_pos = p + count_ext;

  always_comb begin
    status.clr_last     = (clr_cnt == ADDR_W'(ffpa_pkg::NUM_PAGES - 1));
    status.p_end        = (p >= tp);
    status.p_before_idx = (p < idx_ext);
    status.count_zero   = (req_count == '0);
    status.mode_free    = (req_mode == ffpa_pkg::MODE_FREE);
    status.idx_out      = (idx_ext >= tp);
    status.fit          = rd.start && !rd.used && (rd.len >= count_ext);
    status.split        = (rd.len > count_ext);
    status.idx_ok       = rd.start && rd.used;
    status.nxt_in       = (nxt < tp);
    status.nxt_free     = rd.start && !rd.used;
    status.prev_merge   = has_prev && (p == idx_ext) && prev_start && !prev_used;
  end

  // Memory port selection for the current command.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (cmd.op)
      ffpa_pkg::DP_CLR_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
      end
      ffpa_pkg::DP_INIT_RES: begin
        wr_en   = 1'b1;
        wr_data = '{start: 1'b1, used: 1'b1, len: rp, owner: '0};
      end
      ffpa_pkg::DP_INIT_FREE: begin
        wr_en   = 1'b1;
        wr_addr = rp[ADDR_W-1:0];
        wr_data = '{start: 1'b1, used: 1'b0, len: tp - rp, owner: '0};
      end
      ffpa_pkg::DP_RD_P: begin
        rd_en   = 1'b1;
        rd_addr = p[ADDR_W-1:0];
      end
      ffpa_pkg::DP_RD_IDX: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(req_idx);
      end
      ffpa_pkg::DP_RD_NXT: begin
        rd_en   = 1'b1;
        rd_addr = nxt[ADDR_W-1:0];
      end
      ffpa_pkg::DP_MERGE_NXT: begin
        wr_en   = 1'b1;
        wr_addr = nxt[ADDR_W-1:0];
      end
      ffpa_pkg::DP_WR_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = split_pos[ADDR_W-1:0];
        wr_data = '{start: 1'b1, used: 1'b0, len: rd.len - count_ext, owner: '0};
      end
      ffpa_pkg::DP_WR_ALLOC: begin
        wr_en   = 1'b1;
        wr_addr = p[ADDR_W-1:0];
        wr_data = '{start: 1'b1, used: 1'b1, len: count_ext, owner: req_owner};
      end
      ffpa_pkg::DP_WR_PREV: begin
        wr_en   = 1'b1;
        wr_addr = prev_p;
        wr_data = '{start: 1'b1, used: 1'b0, len: prev_len + cur_len, owner: '0};
      end
      ffpa_pkg::DP_WR_IDX_ZERO: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(req_idx);
      end
      ffpa_pkg::DP_WR_IDX_FREE: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(req_idx);
        wr_data = '{start: 1'b1, used: 1'b0, len: cur_len, owner: '0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages    <= ffpa_pkg::TOTAL_W'(ffpa_pkg::TOTAL_RESET);
      reserved_pages <= ffpa_pkg::RESERVED_W'(ffpa_pkg::RESERVED_RESET);
      clr_cnt        <= '0;
      done           <= 1'b0;
    end else begin
      done <= cmd.res_en;
      if (cfg_wr) begin
        clr_cnt <= '0;
        unique case (cfg_index)
          ffpa_pkg::CFG_TOTAL_PAGES: begin
            total_pages <= cfg_data[ffpa_pkg::TOTAL_W-1:0];
          end
          ffpa_pkg::CFG_RESERVED_PAGES: begin
            reserved_pages <= cfg_data[ffpa_pkg::RESERVED_W-1:0];
          end
          default: begin
          end
        endcase
      end else if (cmd.op == ffpa_pkg::DP_CLR_WRITE) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ffpa_pkg::DP_LOAD_REQ: begin
        req_mode  <= mode;
        req_count <= page_count;
        req_owner <= owner_id;
        req_idx   <= page_index;
        p         <= '0;
        has_prev  <= 1'b0;
      end
      ffpa_pkg::DP_STEP: begin
        prev_p     <= p[ADDR_W-1:0];
        prev_len   <= rd.len;
        prev_start <= rd.start;
        prev_used  <= rd.used;
        has_prev   <= 1'b1;
        p          <= p + step;
      end
      ffpa_pkg::DP_LATCH_IDX: begin
        cur_len <= rd.len;
        nxt     <= idx_ext + rd.len;
      end
      ffpa_pkg::DP_MERGE_NXT: begin
        cur_len <= cur_len + rd.len;
      end
      default: begin
      end
    endcase
    if (cmd.res_en) begin
      ok      <= (cmd.res_err == ffpa_pkg::ERR_NONE);
      err_reg <= cmd.res_err;
      if ((cmd.res_err == ffpa_pkg::ERR_NONE) && (req_mode == ffpa_pkg::MODE_ALLOC)) begin
        start_page <= p[ffpa_pkg::START_W-1:0];
      end else begin
        start_page <= '0;
      end
    end
  end

  assign error_code = err_reg;

endmodule

`default_nettype wire
